/* design/bpe_pkg.sv */
// Shared types, codes and helper functions for the pre-tokenizer splitter.
// Used by every module of the block; depends on nothing else.
package bpe_pkg;

  localparam int OFF_W      = 32;
  localparam int LEN_W      = 32;
  localparam int CP_W       = 21;
  localparam int CPQ_DEPTH  = 4;
  localparam int OUTQ_DEPTH = 4;

  typedef enum logic [2:0] {
    KIND_CONTR  = 3'd0,
    KIND_LETTER = 3'd1,
    KIND_DIGIT  = 3'd2,
    KIND_OTHER  = 3'd3,
    KIND_SPACE  = 3'd4
  } kind_t;

  localparam logic [CP_W-1:0] CP_APOS  = CP_W'('h27);
  localparam logic [CP_W-1:0] CP_SPACE = CP_W'('h20);
  localparam logic [CP_W-1:0] CP_S     = CP_W'('h73);
  localparam logic [CP_W-1:0] CP_T     = CP_W'('h74);
  localparam logic [CP_W-1:0] CP_M     = CP_W'('h6D);
  localparam logic [CP_W-1:0] CP_D     = CP_W'('h64);
  localparam logic [CP_W-1:0] CP_R     = CP_W'('h72);
  localparam logic [CP_W-1:0] CP_V     = CP_W'('h76);
  localparam logic [CP_W-1:0] CP_L     = CP_W'('h6C);
  localparam logic [CP_W-1:0] CP_E     = CP_W'('h65);

  // One decoded codepoint on its way to the piece machine
  typedef struct packed {
    logic [CP_W-1:0]  cp;
    kind_t            cls;
    logic [OFF_W-1:0] off;
    logic [2:0]       len;
    logic             eot;
  } tok_t;

  // One result piece
  typedef struct packed {
    logic [OFF_W-1:0] start;
    logic [LEN_W-1:0] length;
    kind_t            kind;
    logic             last;
  } piece_t;

  function automatic logic [1:0] lead_need(input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    if ((b & 8'hE0) == 8'hC0)      n = 2'd1;
    else if ((b & 8'hF0) == 8'hE0) n = 2'd2;
    else if ((b & 8'hF8) == 8'hF0) n = 2'd3;
    return n;
  endfunction

  function automatic kind_t cp_class(input logic [CP_W-1:0] cp);
    kind_t k;
    k = KIND_OTHER;
    if (cp == CP_SPACE || (cp >= CP_W'('h09) && cp <= CP_W'('h0D)))
      k = KIND_SPACE;
    else if ((cp >= CP_W'('h41) && cp <= CP_W'('h5A)) ||
             (cp >= CP_W'('h61) && cp <= CP_W'('h7A)))
      k = KIND_LETTER;
    else if (cp >= CP_W'('h30) && cp <= CP_W'('h39))
      k = KIND_DIGIT;
    else if ((cp >= CP_W'('hC0) && cp <= CP_W'('hD6)) ||
             (cp >= CP_W'('hD8) && cp <= CP_W'('hF6)) ||
             (cp >= CP_W'('hF8) && cp <= CP_W'('hFF)))
      k = KIND_LETTER;
    return k;
  endfunction

  function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LEN_W] ? {LEN_W{1'b1}} : s[LEN_W-1:0];
  endfunction

endpackage

/* design/bpe_front.sv */
// Front end: byte intake, UTF-8 decode and codepoint classification.
// Depends on bpe_pkg; feeds bpe_cpq.
module bpe_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     in_text_byte,
  input  logic           in_last_byte,
  input  logic           in_push,
  output logic           in_full,
  output bpe_pkg::tok_t  tok,
  output logic           tok_push,
  input  logic           tok_full
);
  import bpe_pkg::*;

  logic [7:0]       pend_r   [4];
  logic [7:0]       pend_nxt [4];
  logic [2:0]       cnt_r, cnt_nxt;
  logic [OFF_W-1:0] base_r, base_nxt;
  logic             last_r, last_nxt;

  logic [7:0]       w   [4];
  logic [7:0]       sh  [4];
  logic [2:0]       wcnt;
  logic             wlast;
  logic             acc;
  logic [1:0]       need, need_r;
  logic             complete, ready_d, d_regs, emit;
  logic [2:0]       clen;
  logic [CP_W-1:0]  cp;

  // A buffer that can still yield a codepoint blocks intake until drained
  assign need_r = lead_need(pend_r[0]);
  assign d_regs = (cnt_r != 3'd0) && (({1'b0, need_r} < cnt_r) || last_r);
  assign in_full = d_regs || tok_full;
  assign acc = in_push && !in_full;

  always_comb begin
    w     = pend_r;
    wcnt  = cnt_r;
    wlast = last_r;
    if (acc) begin
      w[cnt_r[1:0]] = in_text_byte;
      wcnt          = cnt_r + 3'd1;
      wlast         = in_last_byte;
    end
  end

  assign need     = lead_need(w[0]);
  assign complete = ({1'b0, need} < wcnt);
  assign ready_d  = (wcnt != 3'd0) && (complete || wlast);
  assign emit     = ready_d && !tok_full;
  assign clen     = complete ? ({1'b0, need} + 3'd1) : 3'd1;

  always_comb begin
    cp = CP_W'(w[0]);
    if (complete) begin
      case (need)
        2'd1:    cp = CP_W'({w[0][4:0], w[1][5:0]});
        2'd2:    cp = CP_W'({w[0][3:0], w[1][5:0], w[2][5:0]});
        2'd3:    cp = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
        default: cp = CP_W'(w[0]);
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (3'(i) + clen < 3'd4) sh[i] = w[2'(3'(i) + clen)];
      else                     sh[i] = 8'h00;
    end
  end

  always_comb begin
    tok.cp   = cp;
    tok.cls  = cp_class(cp);
    tok.off  = base_r;
    tok.len  = clen;
    tok.eot  = wlast && (wcnt == clen);
    tok_push = emit;
  end

  always_comb begin
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    base_nxt = base_r;
    last_nxt = last_r;
    if (emit) begin
      pend_nxt = sh;
      cnt_nxt  = wcnt - clen;
      base_nxt = base_r + OFF_W'(clen);
      last_nxt = wlast;
      // End of text: restart offsets for the next text
      if (wlast && (wcnt == clen)) begin
        base_nxt = '0;
        last_nxt = 1'b0;
      end
    end else if (acc) begin
      pend_nxt = w;
      cnt_nxt  = wcnt;
      last_nxt = wlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      base_r <= '0;
      last_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      base_r <= base_nxt;
      last_r <= last_nxt;
    end
    pend_r <= pend_nxt;
  end

endmodule

/* design/bpe_cpq.sv */
// Short codepoint queue between the decoder and the piece machine.
// Depends on bpe_pkg.
module bpe_cpq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bpe_pkg::tok_t din,
  output logic          full,
  input  logic          pop,
  output bpe_pkg::tok_t dout,
  output logic          empty
);
  import bpe_pkg::*;

  localparam int PW = $clog2(CPQ_DEPTH);

  tok_t          mem [CPQ_DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [PW:0]   cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (PW+1)'(CPQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = mem[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + PW'(1);
      if (do_pop)  rd_r <= rd_r + PW'(1);
      cnt_r <= cnt_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
    if (do_push) mem[wr_r] <= din;
  end

endmodule

/* design/bpe_back.sv */
// Back end: three-codepoint window and piece machine (runs, spaces,
// contractions). Depends on bpe_pkg; reads bpe_cpq, writes bpe_outq.
module bpe_back (
  input  logic            clk,
  input  logic            rst_n,
  input  bpe_pkg::tok_t   tok,
  input  logic            tok_empty,
  output logic            tok_pop,
  output bpe_pkg::piece_t piece,
  output logic            piece_push,
  input  logic            piece_full
);
  import bpe_pkg::*;

  // Lookahead window
  logic [CP_W-1:0]  la_cp_r  [3];
  kind_t            la_cls_r [3];
  logic [OFF_W-1:0] la_off_r [3];
  logic [2:0]       la_len_r [3];
  logic [1:0]       la_cnt_r;
  logic             end_r;

  logic [CP_W-1:0]  la_cp_nxt  [3];
  kind_t            la_cls_nxt [3];
  logic [OFF_W-1:0] la_off_nxt [3];
  logic [2:0]       la_len_nxt [3];
  logic [1:0]       la_cnt_nxt;
  logic             end_nxt;

  // Open piece and whitespace run bookkeeping
  logic             open_r, open_nxt;
  kind_t            kind_r, kind_nxt;
  logic [OFF_W-1:0] ostart_r, ostart_nxt;
  logic [LEN_W-1:0] olen_r, olen_nxt;
  logic [LEN_W-1:0] wsp_r, wsp_nxt;
  logic             wsl_sp_r, wsl_sp_nxt;
  logic [OFF_W-1:0] wsl_off_r, wsl_off_nxt;
  logic [2:0]       wsl_len_r, wsl_len_nxt;
  logic             wmany_r, wmany_nxt;

  logic             emit, fin, commit, load;
  logic [1:0]       popn, popn_eff, cnt_after;
  logic [CP_W-1:0]  want;
  logic             want_ok, quick;

  always_comb begin
    quick = (la_cp_r[1] == CP_S) || (la_cp_r[1] == CP_T) ||
            (la_cp_r[1] == CP_M) || (la_cp_r[1] == CP_D);
    want    = CP_E;
    want_ok = 1'b0;
    if (la_cp_r[1] == CP_R || la_cp_r[1] == CP_V) begin
      want    = CP_E;
      want_ok = 1'b1;
    end else if (la_cp_r[1] == CP_L) begin
      want    = CP_L;
      want_ok = 1'b1;
    end
  end

  // One step of the piece machine, at most one piece per cycle
  always_comb begin
    open_nxt    = open_r;
    kind_nxt    = kind_r;
    ostart_nxt  = ostart_r;
    olen_nxt    = olen_r;
    wsp_nxt     = wsp_r;
    wsl_sp_nxt  = wsl_sp_r;
    wsl_off_nxt = wsl_off_r;
    wsl_len_nxt = wsl_len_r;
    wmany_nxt   = wmany_r;
    popn        = 2'd0;
    emit        = 1'b0;
    fin         = 1'b0;
    piece       = '{start: ostart_r, length: olen_r, kind: kind_r, last: 1'b0};

    if (la_cnt_r != 2'd0) begin
      if (open_r && kind_r != KIND_SPACE) begin
        if (la_cls_r[0] == kind_r) begin
          olen_nxt = sat_add(olen_r, LEN_W'(la_len_r[0]));
          popn     = 2'd1;
        end else begin
          emit     = 1'b1;
          open_nxt = 1'b0;
        end
      end else if (open_r) begin
        if (la_cls_r[0] == KIND_SPACE) begin
          wsp_nxt     = sat_add(wsp_r, LEN_W'(wsl_len_r));
          wmany_nxt   = 1'b1;
          wsl_sp_nxt  = (la_cp_r[0] == CP_SPACE);
          wsl_off_nxt = la_off_r[0];
          wsl_len_nxt = la_len_r[0];
          popn        = 2'd1;
        end else if (wmany_r) begin
          // Flush the run minus its last character; revisit next cycle
          emit         = 1'b1;
          piece.length = wsp_r;
          piece.kind   = KIND_SPACE;
          wmany_nxt    = 1'b0;
        end else if (wsl_sp_r) begin
          kind_nxt   = la_cls_r[0];
          ostart_nxt = wsl_off_r;
          olen_nxt   = LEN_W'(wsl_len_r) + LEN_W'(la_len_r[0]);
          popn       = 2'd1;
        end else begin
          emit         = 1'b1;
          piece.start  = wsl_off_r;
          piece.length = LEN_W'(wsl_len_r);
          piece.kind   = KIND_SPACE;
          open_nxt     = 1'b0;
        end
      end else if (la_cp_r[0] == CP_APOS) begin
        if (la_cnt_r < 2'd2) begin
          if (end_r) begin
            open_nxt   = 1'b1;
            kind_nxt   = KIND_OTHER;
            ostart_nxt = la_off_r[0];
            olen_nxt   = LEN_W'(la_len_r[0]);
            popn       = 2'd1;
          end
        end else if (quick) begin
          emit         = 1'b1;
          piece.start  = la_off_r[0];
          piece.length = LEN_W'(la_len_r[0]) + LEN_W'(la_len_r[1]);
          piece.kind   = KIND_CONTR;
          piece.last   = end_r && (la_cnt_r == 2'd2);
          popn         = 2'd2;
        end else if (want_ok && la_cnt_r < 2'd3) begin
          if (end_r) begin
            open_nxt   = 1'b1;
            kind_nxt   = KIND_OTHER;
            ostart_nxt = la_off_r[0];
            olen_nxt   = LEN_W'(la_len_r[0]);
            popn       = 2'd1;
          end
        end else if (want_ok && la_cp_r[2] == want) begin
          emit         = 1'b1;
          piece.start  = la_off_r[0];
          piece.length = LEN_W'(la_len_r[0]) + LEN_W'(la_len_r[1]) +
                         LEN_W'(la_len_r[2]);
          piece.kind   = KIND_CONTR;
          piece.last   = end_r;
          popn         = 2'd3;
        end else begin
          open_nxt   = 1'b1;
          kind_nxt   = KIND_OTHER;
          ostart_nxt = la_off_r[0];
          olen_nxt   = LEN_W'(la_len_r[0]);
          popn       = 2'd1;
        end
      end else begin
        open_nxt   = 1'b1;
        kind_nxt   = la_cls_r[0];
        ostart_nxt = la_off_r[0];
        olen_nxt   = LEN_W'(la_len_r[0]);
        popn       = 2'd1;
        if (la_cls_r[0] == KIND_SPACE) begin
          wsp_nxt     = '0;
          wmany_nxt   = 1'b0;
          wsl_sp_nxt  = (la_cp_r[0] == CP_SPACE);
          wsl_off_nxt = la_off_r[0];
          wsl_len_nxt = la_len_r[0];
        end
      end
    end else if (end_r) begin
      // Window drained at end of text: close out the open piece
      fin      = 1'b1;
      emit     = open_r;
      open_nxt = 1'b0;
      piece.last = 1'b1;
      if (kind_r == KIND_SPACE) begin
        piece.length = sat_add(wsp_r, LEN_W'(wsl_len_r));
      end
    end
  end

  assign commit     = !(emit && piece_full);
  assign piece_push = emit && !piece_full;
  assign popn_eff   = commit ? popn : 2'd0;
  assign cnt_after  = la_cnt_r - popn_eff;
  assign load       = !end_r && !tok_empty && (cnt_after != 2'd3);
  assign tok_pop    = load;

  // Window shift and refill
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (3'(i) + 3'(popn_eff) < 3'd3) begin
        la_cp_nxt[i]  = la_cp_r[2'(i + int'(popn_eff))];
        la_cls_nxt[i] = la_cls_r[2'(i + int'(popn_eff))];
        la_off_nxt[i] = la_off_r[2'(i + int'(popn_eff))];
        la_len_nxt[i] = la_len_r[2'(i + int'(popn_eff))];
      end else begin
        la_cp_nxt[i]  = la_cp_r[i];
        la_cls_nxt[i] = la_cls_r[i];
        la_off_nxt[i] = la_off_r[i];
        la_len_nxt[i] = la_len_r[i];
      end
    end
    la_cnt_nxt = cnt_after;
    end_nxt    = end_r;
    if (commit && fin) end_nxt = 1'b0;
    if (load) begin
      la_cp_nxt[cnt_after]  = tok.cp;
      la_cls_nxt[cnt_after] = tok.cls;
      la_off_nxt[cnt_after] = tok.off;
      la_len_nxt[cnt_after] = tok.len;
      la_cnt_nxt            = cnt_after + 2'd1;
      end_nxt               = tok.eot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      la_cnt_r <= '0;
      end_r    <= 1'b0;
      open_r   <= 1'b0;
      wmany_r  <= 1'b0;
    end else begin
      la_cnt_r <= la_cnt_nxt;
      end_r    <= end_nxt;
      if (commit) begin
        open_r  <= open_nxt;
        wmany_r <= wmany_nxt;
      end
    end
    la_cp_r  <= la_cp_nxt;
    la_cls_r <= la_cls_nxt;
    la_off_r <= la_off_nxt;
    la_len_r <= la_len_nxt;
    if (commit) begin
      kind_r    <= kind_nxt;
      ostart_r  <= ostart_nxt;
      olen_r    <= olen_nxt;
      wsp_r     <= wsp_nxt;
      wsl_sp_r  <= wsl_sp_nxt;
      wsl_off_r <= wsl_off_nxt;
      wsl_len_r <= wsl_len_nxt;
    end
  end

endmodule

/* design/bpe_outq.sv */
// Result queue: holds finished pieces until the receiver pops them.
// Depends on bpe_pkg.
module bpe_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bpe_pkg::piece_t din,
  output logic            full,
  input  logic            pop,
  output bpe_pkg::piece_t dout,
  output logic            empty
);
  import bpe_pkg::*;

  localparam int PW = $clog2(OUTQ_DEPTH);

  piece_t        mem [OUTQ_DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [PW:0]   cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (PW+1)'(OUTQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = mem[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + PW'(1);
      if (do_pop)  rd_r <= rd_r + PW'(1);
      cnt_r <= cnt_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
    if (do_push) mem[wr_r] <= din;
  end

endmodule

/* design/bpe_pretokenizer_splitter.sv */
// Top level of the pre-tokenizer splitter: decoder, codepoint queue,
// piece machine and result queue. Depends on bpe_pkg and all bpe_ modules.
//
// Usage: push text bytes on in_text_byte with in_push while in_full is low;
// raise in_last_byte on the final byte of each text. Pieces come out as a
// queue: while out_empty is low, out_piece_start/length/kind/last_piece
// show the oldest piece; pop it with out_pop. out_last_piece marks the
// final piece of each text.
// Throughput: up to one byte per cycle. The decoder yields one codepoint a
// cycle while the codepoint queue is not full; a final byte that leaves an
// unfinished UTF-8 sequence holds in_full high while the leftover bytes drain
// as raw codepoints. The piece machine takes one step per cycle while the
// result queue is not full. Every piece it closes in the middle of a text,
// contractions aside, costs one step that consumes no codepoint. Each text
// ends with a close-out step, after which the window reloads for the next
// text. A piece reaches the result side by way of the codepoint queue, the
// window registers and the result queue.
// Reset (rst_n low, synchronous) empties both queues, the decoder buffer
// and the window, and restarts offsets at zero.
// When the receiver stalls, the result queue fills, the piece machine
// holds, the codepoint queue fills, and in_full rises; nothing is dropped.
module bpe_pretokenizer_splitter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_text_byte,
  input  logic        in_last_byte,
  input  logic        in_push,
  output logic        in_full,
  output logic [31:0] out_piece_start,
  output logic [31:0] out_piece_length,
  output logic [2:0]  out_piece_kind,
  output logic        out_last_piece,
  output logic        out_empty,
  input  logic        out_pop
);
  import bpe_pkg::*;

  tok_t   f_tok, q_tok;
  logic   f_push, q_full, q_empty, b_pop;
  piece_t b_piece, o_piece;
  logic   b_push, o_full;

  bpe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_text_byte (in_text_byte),
    .in_last_byte (in_last_byte),
    .in_push      (in_push),
    .in_full      (in_full),
    .tok          (f_tok),
    .tok_push     (f_push),
    .tok_full     (q_full)
  );

  // Decouple decode from piece building so each side can stall alone
  bpe_cpq u_cpq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (f_tok),
    .full  (q_full),
    .pop   (b_pop),
    .dout  (q_tok),
    .empty (q_empty)
  );

  bpe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok        (q_tok),
    .tok_empty  (q_empty),
    .tok_pop    (b_pop),
    .piece      (b_piece),
    .piece_push (b_push),
    .piece_full (o_full)
  );

  bpe_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (b_push),
    .din   (b_piece),
    .full  (o_full),
    .pop   (out_pop),
    .dout  (o_piece),
    .empty (out_empty)
  );

  assign out_piece_start  = o_piece.start;
  assign out_piece_length = o_piece.length;
  assign out_piece_kind   = o_piece.kind;
  assign out_last_piece   = o_piece.last;

endmodule

/* tb/bpe_pretokenizer_splitter_checker.sv */
// Checker for the pre-tokenizer splitter: watches both queue ports,
// predicts the piece stream from the accepted bytes and compares.
// Depends on bpe_pkg for the piece kinds and codepoint constants.
module bpe_pretokenizer_splitter_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_text_byte,
  input  logic        in_last_byte,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [31:0] out_piece_start,
  input  logic [31:0] out_piece_length,
  input  logic [2:0]  out_piece_kind,
  input  logic        out_last_piece,
  input  logic        out_empty,
  input  logic        out_pop,
  output int          errors,
  output int          pieces_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import bpe_pkg::*;

  localparam int MAX_PER_STEP = 4;

  piece_t      piece_q[$];

  logic [31:0] byte_cnt;
  logic [7:0]  part_b[3];
  int          part_n;
  logic [20:0] win_cp[3];
  logic [31:0] win_off[3];
  logic [31:0] win_len[3];
  int          win_n;
  logic        run_open;
  kind_t       run_kind;
  logic [31:0] run_start;
  logic [31:0] run_len;
  logic [31:0] ws_head_len;
  logic [20:0] ws_tail_cp;
  logic [31:0] ws_tail_off;
  logic [31:0] ws_tail_len;
  logic        ws_multi;
  int          step_pieces;
  int          carry_pieces;

  function automatic logic [31:0] sadd(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic kind_t classify(logic [20:0] cp);
    if (cp == 21'h20 || (cp >= 21'h09 && cp <= 21'h0D)) return KIND_SPACE;
    if ((cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'h61 && cp <= 21'h7A)) return KIND_LETTER;
    if (cp >= 21'h30 && cp <= 21'h39) return KIND_DIGIT;
    if ((cp >= 21'hC0 && cp <= 21'hFF) && cp != 21'hD7 && cp != 21'hF7) return KIND_LETTER;
    return KIND_OTHER;
  endfunction

  function automatic int seq_need(logic [7:0] b);
    if (b[7:5] == 3'b110) return 1;
    if (b[7:4] == 4'b1110) return 2;
    if (b[7:3] == 5'b11110) return 3;
    return 0;
  endfunction

  task automatic add_piece(logic [31:0] st, logic [31:0] ln, kind_t k);
    piece_t p;
    p.start  = st;
    p.length = ln;
    p.kind   = k;
    p.last   = 1'b0;
    piece_q  = {piece_q, p};
    step_pieces++;
  endtask

  task automatic drop_window(int n);
    for (int i = 0; i + n < win_n && i + n < 3; i++) begin
      win_cp[i]  = win_cp[i+n];
      win_off[i] = win_off[i+n];
      win_len[i] = win_len[i+n];
    end
    win_n = (n >= win_n) ? 0 : win_n - n;
  endtask

  task automatic begin_run(kind_t k, logic [31:0] st, logic [31:0] ln);
    run_open  = 1'b1;
    run_kind  = k;
    run_start = st;
    run_len   = ln;
  endtask

  // Walk the window until it runs dry or a contraction needs more lookahead
  task automatic walk_window(logic at_end);
    logic [20:0] cp, nxt, want;
    logic [31:0] ln0, of0;
    kind_t       cls;
    while (win_n > 0) begin
      cp  = win_cp[0];
      ln0 = win_len[0];
      of0 = win_off[0];
      cls = classify(cp);
      if (run_open && run_kind != KIND_SPACE) begin
        if (cls == run_kind) begin
          run_len = sadd(run_len, ln0);
          drop_window(1);
        end else begin
          add_piece(run_start, run_len, run_kind);
          run_open = 1'b0;
        end
      end else if (run_open) begin
        if (cls == KIND_SPACE) begin
          ws_head_len = sadd(ws_head_len, ws_tail_len);
          ws_multi    = 1'b1;
          ws_tail_cp  = cp;
          ws_tail_off = of0;
          ws_tail_len = ln0;
          drop_window(1);
        end else begin
          if (ws_multi) add_piece(run_start, ws_head_len, KIND_SPACE);
          // a trailing plain space joins the following run
          if (ws_tail_cp == CP_SPACE) begin
            begin_run(cls, ws_tail_off, sadd(ws_tail_len, ln0));
            drop_window(1);
          end else begin
            add_piece(ws_tail_off, ws_tail_len, KIND_SPACE);
            run_open = 1'b0;
          end
        end
      end else if (cp == CP_APOS) begin
        if (win_n < 2) begin
          if (!at_end) return;
          begin_run(KIND_OTHER, of0, ln0);
          drop_window(1);
          continue;
        end
        nxt = win_cp[1];
        if (nxt == CP_S || nxt == CP_T || nxt == CP_M || nxt == CP_D) begin
          add_piece(of0, sadd(ln0, win_len[1]), KIND_CONTR);
          drop_window(2);
          continue;
        end
        want = '0;
        if (nxt == CP_R || nxt == CP_V) want = CP_E;
        else if (nxt == CP_L) want = CP_L;
        if (want != '0) begin
          if (win_n < 3) begin
            if (!at_end) return;
          end else if (win_cp[2] == want) begin
            add_piece(of0, sadd(sadd(ln0, win_len[1]), win_len[2]), KIND_CONTR);
            drop_window(3);
            continue;
          end
        end
        begin_run(KIND_OTHER, of0, ln0);
        drop_window(1);
      end else begin
        if (cls == KIND_SPACE) begin
          begin_run(KIND_SPACE, of0, 32'd0);
          ws_head_len = '0;
          ws_multi    = 1'b0;
          ws_tail_cp  = cp;
          ws_tail_off = of0;
          ws_tail_len = ln0;
        end else begin
          begin_run(cls, of0, ln0);
        end
        drop_window(1);
      end
    end
  endtask

  task automatic take_cp(logic [20:0] cp, logic [31:0] of, logic [31:0] ln);
    if (win_n < 3) begin
      win_cp[win_n]  = cp;
      win_off[win_n] = of;
      win_len[win_n] = ln;
      win_n++;
    end
    walk_window(1'b0);
  endtask

  task automatic clear_text();
    byte_cnt    = '0;
    part_n      = 0;
    win_n       = 0;
    run_open    = 1'b0;
    run_kind    = KIND_CONTR;
    run_start   = '0;
    run_len     = '0;
    ws_head_len = '0;
    ws_tail_cp  = '0;
    ws_tail_off = '0;
    ws_tail_len = '0;
    ws_multi    = 1'b0;
  endtask

  task automatic split_byte(logic [7:0] b, logic fin);
    logic [7:0]  buff[4];
    logic [31:0] base;
    logic [20:0] cp;
    int          avail, pos, need;
    step_pieces = carry_pieces;
    for (int i = 0; i < part_n; i++) buff[i] = part_b[i];
    buff[part_n] = b;
    avail    = part_n + 1;
    base     = byte_cnt - part_n;
    byte_cnt = byte_cnt + 1;
    pos      = 0;
    while (pos < avail) begin
      need = seq_need(buff[pos]);
      if (pos + need < avail) begin
        case (need)
          0: cp = {13'b0, buff[pos]};
          1: cp = {10'b0, buff[pos][4:0], buff[pos+1][5:0]};
          2: cp = {5'b0, buff[pos][3:0], buff[pos+1][5:0], buff[pos+2][5:0]};
          default: cp = {buff[pos][2:0], buff[pos+1][5:0], buff[pos+2][5:0],
                         buff[pos+3][5:0]};
        endcase
        take_cp(cp, base + pos, need + 1);
        pos += need + 1;
      end else if (fin) begin
        // short lead at end of text: the byte stands alone
        take_cp({13'b0, buff[pos]}, base + pos, 32'd1);
        pos++;
      end else begin
        break;
      end
    end
    part_n = 0;
    while (pos < avail && part_n < 3) begin
      part_b[part_n] = buff[pos];
      part_n++;
      pos++;
    end
    if (fin) begin
      walk_window(1'b1);
      if (run_open) begin
        if (run_kind == KIND_SPACE)
          add_piece(run_start, sadd(ws_head_len, ws_tail_len), KIND_SPACE);
        else
          add_piece(run_start, run_len, run_kind);
      end
      if (step_pieces > 0) piece_q[$].last = 1'b1;
      clear_text();
    end
    // surplus pieces stay in order; only their count matters for marking
    carry_pieces = (step_pieces > MAX_PER_STEP) ? step_pieces - MAX_PER_STEP : 0;
  endtask

  task automatic report(string what);
    $display("%0t mismatch: %s", $realtime, what);
    errors++;
  endtask

  initial begin
    errors       = 0;
    pieces_due   = 0;
    carry_pieces = 0;
    clear_text();
  end

  always @(posedge clk) begin
    piece_t want_p;
    if (!rst_n) begin
      piece_q.delete();
      carry_pieces = 0;
      clear_text();
    end else begin
      if (out_pop && !out_empty) begin
        if (piece_q.size() == 0) begin
          report($sformatf("unexpected piece start %0d length %0d",
                           out_piece_start, out_piece_length));
        end else begin
          want_p = piece_q.pop_front();
          if (out_piece_start !== want_p.start)
            report($sformatf("start %0d, want %0d", out_piece_start, want_p.start));
          if (out_piece_length !== want_p.length)
            report($sformatf("length %0d, want %0d", out_piece_length, want_p.length));
          if (out_piece_kind !== want_p.kind)
            report($sformatf("kind %0d, want %0d", out_piece_kind, want_p.kind));
          if (out_last_piece !== want_p.last)
            report($sformatf("last %0b, want %0b", out_last_piece, want_p.last));
        end
      end
      if (in_push && !in_full) split_byte(in_text_byte, in_last_byte);
    end
    pieces_due = piece_q.size();
  end

endmodule

/* tb/tb_bpe_pretokenizer_splitter.sv */
// Testbench top for the pre-tokenizer splitter: clock, reset, text stimulus
// and verdict. Depends on bpe_pkg, the block and the splitter checker.
module tb_bpe_pretokenizer_splitter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;  // cycles without any transfer
  localparam int SQUEEZE_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [7:0]  in_text_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [31:0] out_piece_start;
  logic [31:0] out_piece_length;
  logic [2:0]  out_piece_kind;
  logic        out_last_piece;
  logic        out_empty;
  logic        out_pop = 1'b0;
  int          errors;
  int          pieces_due;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          squeeze_req = 1'b0;
  int          quiet_cycles = 0;
  logic [8:0]  text_q[$];  // {last flag, byte}

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  bpe_pretokenizer_splitter u_top (.*);

  bpe_pretokenizer_splitter_checker u_chk (.*);

  // Watchdog: end the run if neither side transfers for too long
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("bpe_pretokenizer_splitter verification failed");
      $finish;
    end
  end

  // Receiver: pop at random, or hold off for a long stretch on request
  initial begin
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        out_pop <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeeze_req = 1'b0;
      end
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one byte and hold it until the block takes it
  task automatic send_byte(logic [7:0] b, logic fin);
    in_text_byte <= b;
    in_last_byte <= fin;
    in_push      <= 1'b1;
    do @(posedge clk); while (in_full);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Append one {last flag, byte} entry to the text queue
  task automatic put_byte(logic [8:0] v);
    text_q = {text_q, v};
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) put_byte({1'b0, s[i]});
  endtask

  // Build one text out of random segments; mostly well-formed words
  task automatic make_text(int segs);
    int  n;
    byte b;
    for (int s = 0; s < segs; s++) begin
      n = $urandom_range(1, 4);
      case ($urandom_range(9))
        0, 1: repeat (n) put_byte({1'b0, 8'($urandom_range(8'h61, 8'h7A))});
        2: repeat ($urandom_range(1, 3)) begin
             case ($urandom_range(5))
               0: b = 8'h09;
               1: b = 8'($urandom_range(8'h0A, 8'h0D));
               default: b = 8'h20;
             endcase
             put_byte({1'b0, b});
           end
        3: repeat (n) put_byte({1'b0, 8'($urandom_range(8'h30, 8'h39))});
        4: begin
             put_byte({1'b0, 8'h27});
             case ($urandom_range(8))
               0: push_str("s");
               1: push_str("t");
               2: push_str("m");
               3: push_str("d");
               4: push_str("re");
               5: push_str("ve");
               6: push_str("ll");
               7: push_str("rx");
               default: push_str("q");
             endcase
           end
        5: repeat (n) put_byte({1'b0, 8'($urandom_range(8'h21, 8'h2F))});
        6: repeat (n) begin
             put_byte({1'b0, 8'($urandom_range(8'hC2, 8'hC3))});
             put_byte({1'b0, 8'($urandom_range(8'h80, 8'hBF))});
           end
        7: begin
             push_str("\xE2\x80\x94");
             if ($urandom_range(1)) push_str("\xF0\x9F\x98\x80");
           end
        8: put_byte({1'b0, 8'($urandom_range(8'h80, 8'hFF))});
        default: repeat (n) put_byte({1'b0, 8'($urandom_range(255))});
      endcase
    end
    // sometimes cut a sequence short at the end of text
    if ($urandom_range(7) == 0) begin
      put_byte({1'b0, 8'hC3 + 8'($urandom_range(2)) * 8'h10});
      if ($urandom_range(1)) put_byte({1'b0, 8'h80});
    end
    text_q[$][8] = 1'b1;
  endtask

  task automatic drain_texts();
    logic [8:0] item;
    while (text_q.size() > 0) begin
      item = text_q.pop_front();
      send_byte(item[7:0], item[8]);
    end
  endtask

  task automatic run_phase(int idle, int stall, int n_bytes, bit squeeze);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    if (squeeze) squeeze_req = 1'b1;
    while (text_q.size() < n_bytes) make_text($urandom_range(1, 6));
    drain_texts();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed texts: contractions, whitespace runs, stray and short leads
    push_str("it's we'll 42  x\t\ta'");
    text_q[$][8] = 1'b1;
    put_byte({1'b1, 8'hFF});
    put_byte({1'b0, 8'h00});
    put_byte({1'b1, 8'hE2});
    drain_texts();

    run_phase(0, 0, 105, 1'b1);
    run_phase(68, 0, 105, 1'b0);
    run_phase(0, 68, 105, 1'b0);
    run_phase(11, 11, 105, 1'b0);

    in_push <= 1'b0;
    while (pieces_due != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pieces_due == 0)
      $display("bpe_pretokenizer_splitter verification clean");
    else
      $display("bpe_pretokenizer_splitter verification failed");
    $finish;
  end

endmodule
